@@ sv/ray_sphere_nearest_hit_assert.svh @@
// Assertion macros shared by the ray/sphere nearest hit block.
`ifndef RAY_SPHERE_NEAREST_HIT_ASSERT_SVH
`define RAY_SPHERE_NEAREST_HIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RSNH_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsnh same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RSNH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsnh next-cycle check failed");

`endif

@@ sv/rsnh_pkg.sv @@
// Package with types, constants and helper functions of the ray/sphere nearest hit block.
package rsnh_pkg;

    localparam int MAX_SPHERES = 16;
    localparam int IDX_W       = $clog2(MAX_SPHERES);
    localparam int CNT_W       = 5;
    localparam int SQRT_STEPS  = 29;
    localparam int DIV_STEPS   = 15;

    localparam logic [1:0] CFG_CAMERA_X     = 2'd0;
    localparam logic [1:0] CFG_CAMERA_Y     = 2'd1;
    localparam logic [1:0] CFG_CAMERA_Z     = 2'd2;
    localparam logic [1:0] CFG_SPHERE_COUNT = 2'd3;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_TRACE = 1'b1;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic        [30:0] r;
    } entry_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } mem_ctrl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_OC,
        S_MUL,
        S_SUM,
        S_HSQ,
        S_DISC,
        S_SQRT,
        S_ROOT,
        S_FIN,
        S_PMUL,
        S_PADD,
        S_DIV,
        S_NORM,
        S_DONE
    } state_t;

    function automatic logic signed [31:0] sat39(input logic signed [38:0] v);
        logic signed [31:0] res;
        if (v > 39'sd2147483647)
        begin
            res = 32'sh7fffffff;
        end
        else if (v < -39'sd2147483648)
        begin
            res = 32'sh80000000;
        end
        else
        begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
        logic signed [31:0] res;
        if (v > 35'sd2147483647)
        begin
            res = 32'sh7fffffff;
        end
        else if (v < -35'sd2147483648)
        begin
            res = 32'sh80000000;
        end
        else
        begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

@@ sv/rsnh_table.sv @@
// Sphere table memory with one write port and one registered read port.
module rsnh_table
    import rsnh_pkg::*;
(
    input  logic      clk,
    input  mem_ctrl_t ctl,
    input  entry_t    wr_data,
    output entry_t    rd_data
);

    entry_t mem [MAX_SPHERES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[ctl.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/ray_sphere_nearest_hit.sv @@
// Top level of the ray/sphere nearest hit block: sequencer, arithmetic and result register.
// A trace visits the sphere slots in turn: an empty slot is skipped, a sphere with a negative
// discriminant is dropped, and a sphere that is hit runs the 29-step square root. When one
// was hit, the trace finishes with the 15-step divider, run once per normal component unless
// that component saturates. One trace is worked at a time; loads are taken between.
// Reset sets the camera to (1.0, 2.0, 1.0), the sphere count to zero and empties the output.
`include "ray_sphere_nearest_hit_assert.svh"
module ray_sphere_nearest_hit
    import rsnh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic [3:0]         entry_index,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic signed [31:0] center_z,
    input  logic [30:0]        radius,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  logic signed [15:0] dir_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic [3:0]         hit_index,
    output logic signed [31:0] t_entry,
    output logic signed [31:0] t_exit,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic signed [31:0] point_z,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z
);

    state_t state_reg, state_next;

    logic signed [31:0] cam_reg [3];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   limit;

    logic [IDX_W:0]     idx_reg;
    logic [1:0]         k_reg;
    logic [4:0]         step_reg;
    logic               found_reg;
    logic               out_valid_reg;
    logic               out_load;
    logic               accept_in;

    mem_ctrl_t          mem_ctl;
    entry_t             wr_entry;
    entry_t             rd_entry;
    logic signed [31:0] c_rd [3];

    logic signed [15:0] dir_reg [3];
    logic signed [32:0] oc_reg [3];
    logic signed [50:0] h_reg;
    logic        [50:0] s2_reg;
    logic signed [36:0] h16_reg;
    logic signed [28:0] hq_reg;
    logic        [45:0] rqsq_reg;
    logic        [56:0] hqsq_reg;
    logic        [57:0] rad_reg;
    logic        [30:0] rem_reg;
    logic        [28:0] root_reg;

    logic        [38:0] best_abs_reg;
    logic signed [38:0] bt0_reg;
    logic signed [38:0] bt1_reg;
    logic signed [31:0] bc_reg [3];
    logic        [30:0] br_reg;
    logic [IDX_W-1:0]   best_idx_reg;

    logic signed [31:0] te_reg;
    logic signed [31:0] tx_reg;
    logic signed [47:0] prod_reg;
    logic signed [31:0] p_reg [3];
    logic signed [15:0] n_reg [3];
    logic               neg_reg;
    logic               nsat_reg;
    logic        [30:0] drem_reg;
    logic        [14:0] dlow_reg;
    logic        [14:0] quo_reg;

    logic               out_hit_reg;
    logic [3:0]         out_idx_reg;
    logic signed [31:0] out_te_reg;
    logic signed [31:0] out_tx_reg;
    logic signed [31:0] out_p_reg [3];
    logic signed [15:0] out_n_reg [3];

    logic signed [48:0] dprod_w;
    logic signed [24:0] q_w;
    logic signed [49:0] qsq_w;
    logic signed [57:0] hqsq_w;
    logic        [22:0] rq_w;
    logic signed [58:0] disc_w;
    logic        [32:0] srem2_w;
    logic        [32:0] trial_w;
    logic signed [38:0] sq_w;
    logic signed [38:0] h16e_w;
    logic signed [38:0] t0_w;
    logic signed [38:0] t1_w;
    logic        [38:0] abs_w;
    logic signed [34:0] psum_w;
    logic signed [31:0] p_w;
    logic signed [32:0] diff_w;
    logic        [32:0] mag_w;
    logic        [46:0] num_w;
    logic               nsat_w;
    logic        [31:0] drem2_w;
    logic        [14:0] nmag_w;

    rsnh_table u_table (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_data (wr_entry),
        .rd_data (rd_entry)
    );

    assign limit = (count_reg > CNT_W'(MAX_SPHERES)) ? CNT_W'(MAX_SPHERES) : count_reg;
    assign c_rd[0] = rd_entry.cx;
    assign c_rd[1] = rd_entry.cy;
    assign c_rd[2] = rd_entry.cz;
    assign wr_entry = '{cx: center_x, cy: center_y, cz: center_z, r: radius};
    assign accept_in = in_valid && in_ready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        dprod_w = dir_reg[k_reg] * oc_reg[k_reg];
        q_w     = oc_reg[k_reg][32:8];
        qsq_w   = q_w * q_w;
        rq_w    = rd_entry.r[30:8];
        hqsq_w  = hq_reg * hq_reg;
        disc_w  = $signed({2'b00, hqsq_reg}) - $signed({8'b0, s2_reg})
                  + $signed({13'b0, rqsq_reg});
        srem2_w = {rem_reg, rad_reg[57:56]};
        trial_w = {2'b00, root_reg, 2'b01};
        sq_w    = $signed({2'b00, root_reg, 8'b0});
        h16e_w  = 39'(h16_reg);
        t0_w    = -h16e_w - sq_w;
        t1_w    = -h16e_w + sq_w;
        abs_w   = t0_w[38] ? 39'(-t0_w) : 39'(t0_w);
        psum_w  = 35'(cam_reg[k_reg]) + 35'($signed(prod_reg[47:14]));
        p_w     = sat35(psum_w);
        diff_w  = 33'(p_w) - 33'(bc_reg[k_reg]);
        mag_w   = diff_w[32] ? 33'(-diff_w) : 33'(diff_w);
        num_w   = {mag_w, 14'b0};
        nsat_w  = num_w >= {1'b0, br_reg, 15'b0};
        drem2_w = {drem_reg, dlow_reg[14]};
        nmag_w  = (nsat_reg || quo_reg > 15'd16384) ? 15'd16384 : quo_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept_in && cmd == CMD_TRACE)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = (idx_reg == limit) ? S_FIN : S_READ;
            end
            S_READ:
            begin
                state_next = S_OC;
            end
            S_OC:
            begin
                state_next = (rd_entry.r == '0) ? S_CHECK : S_MUL;
            end
            S_MUL:
            begin
                if (k_reg == 2'd2)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                state_next = S_HSQ;
            end
            S_HSQ:
            begin
                state_next = S_DISC;
            end
            S_DISC:
            begin
                state_next = disc_w[58] ? S_CHECK : S_SQRT;
            end
            S_SQRT:
            begin
                if (step_reg == 5'(SQRT_STEPS - 1))
                begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                state_next = S_CHECK;
            end
            S_FIN:
            begin
                state_next = found_reg ? S_PMUL : S_DONE;
            end
            S_PMUL:
            begin
                state_next = S_PADD;
            end
            S_PADD:
            begin
                state_next = nsat_w ? S_NORM : S_DIV;
            end
            S_DIV:
            begin
                if (step_reg == 5'(DIV_STEPS - 1))
                begin
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                state_next = (k_reg == 2'd2) ? S_DONE : S_PMUL;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = (state_reg == S_IDLE);
        cfg_ready       = 1'b1;
        mem_ctl.wr_en   = (state_reg == S_IDLE) && in_valid && (cmd == CMD_LOAD);
        mem_ctl.wr_addr = entry_index;
        mem_ctl.rd_en   = (state_reg == S_READ);
        mem_ctl.rd_addr = idx_reg[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cam_reg[0]    <= 32'sd65536;
            cam_reg[1]    <= 32'sd131072;
            cam_reg[2]    <= 32'sd65536;
            count_reg     <= '0;
            idx_reg       <= '0;
            k_reg         <= '0;
            step_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CAMERA_X:     cam_reg[0] <= cfg_data;
                    CFG_CAMERA_Y:     cam_reg[1] <= cfg_data;
                    CFG_CAMERA_Z:     cam_reg[2] <= cfg_data;
                    CFG_SPHERE_COUNT: count_reg  <= cfg_data[CNT_W-1:0];
                    default:          count_reg  <= count_reg;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                end
                S_OC:
                begin
                    k_reg <= '0;
                    if (rd_entry.r == '0)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_MUL:
                begin
                    k_reg <= k_reg + 1'b1;
                end
                S_DISC:
                begin
                    step_reg <= '0;
                    if (disc_w[58])
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_SQRT:
                begin
                    step_reg <= step_reg + 1'b1;
                end
                S_ROOT:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (!found_reg || abs_w < best_abs_reg)
                    begin
                        found_reg <= 1'b1;
                    end
                end
                S_FIN:
                begin
                    k_reg <= '0;
                end
                S_PADD:
                begin
                    step_reg <= '0;
                end
                S_DIV:
                begin
                    step_reg <= step_reg + 1'b1;
                end
                S_NORM:
                begin
                    k_reg <= k_reg + 1'b1;
                end
                default:
                begin
                    step_reg <= step_reg;
                end
            endcase
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                dir_reg[0] <= dir_x;
                dir_reg[1] <= dir_y;
                dir_reg[2] <= dir_z;
            end
            S_OC:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    oc_reg[i] <= 33'(cam_reg[i]) - 33'(c_rd[i]);
                end
                h_reg  <= '0;
                s2_reg <= '0;
            end
            S_MUL:
            begin
                h_reg  <= h_reg + 51'(dprod_w);
                s2_reg <= s2_reg + 51'(qsq_w[48:0]);
            end
            S_SUM:
            begin
                h16_reg  <= h_reg[50:14];
                hq_reg   <= h_reg[50:22];
                rqsq_reg <= rq_w * rq_w;
            end
            S_HSQ:
            begin
                hqsq_reg <= hqsq_w[56:0];
            end
            S_DISC:
            begin
                rad_reg  <= disc_w[57:0];
                rem_reg  <= '0;
                root_reg <= '0;
            end
            S_SQRT:
            begin
                rad_reg <= {rad_reg[55:0], 2'b00};
                if (srem2_w >= trial_w)
                begin
                    rem_reg  <= 31'(srem2_w - trial_w);
                    root_reg <= {root_reg[27:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= srem2_w[30:0];
                    root_reg <= {root_reg[27:0], 1'b0};
                end
            end
            S_ROOT:
            begin
                if (!found_reg || abs_w < best_abs_reg)
                begin
                    best_abs_reg <= abs_w;
                    bt0_reg      <= t0_w;
                    bt1_reg      <= t1_w;
                    bc_reg[0]    <= rd_entry.cx;
                    bc_reg[1]    <= rd_entry.cy;
                    bc_reg[2]    <= rd_entry.cz;
                    br_reg       <= rd_entry.r;
                    best_idx_reg <= idx_reg[IDX_W-1:0];
                end
            end
            S_FIN:
            begin
                if (found_reg)
                begin
                    te_reg <= sat39(bt0_reg);
                    tx_reg <= sat39(bt1_reg);
                end
                else
                begin
                    te_reg       <= '0;
                    tx_reg       <= '0;
                    best_idx_reg <= '0;
                    for (int i = 0; i < 3; i++)
                    begin
                        p_reg[i] <= '0;
                        n_reg[i] <= '0;
                    end
                end
            end
            S_PMUL:
            begin
                prod_reg <= dir_reg[k_reg] * te_reg;
            end
            S_PADD:
            begin
                p_reg[k_reg] <= p_w;
                neg_reg      <= diff_w[32];
                nsat_reg     <= nsat_w;
                drem_reg     <= num_w[45:15];
                dlow_reg     <= num_w[14:0];
                quo_reg      <= '0;
            end
            S_DIV:
            begin
                dlow_reg <= {dlow_reg[13:0], 1'b0};
                if (drem2_w >= {1'b0, br_reg})
                begin
                    drem_reg <= 31'(drem2_w - {1'b0, br_reg});
                    quo_reg  <= {quo_reg[13:0], 1'b1};
                end
                else
                begin
                    drem_reg <= drem2_w[30:0];
                    quo_reg  <= {quo_reg[13:0], 1'b0};
                end
            end
            S_NORM:
            begin
                n_reg[k_reg] <= neg_reg ? -$signed({1'b0, nmag_w}) : $signed({1'b0, nmag_w});
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
        if (out_load)
        begin
            out_hit_reg <= found_reg;
            out_idx_reg <= best_idx_reg;
            out_te_reg  <= te_reg;
            out_tx_reg  <= tx_reg;
            for (int i = 0; i < 3; i++)
            begin
                out_p_reg[i] <= p_reg[i];
                out_n_reg[i] <= n_reg[i];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = out_hit_reg;
    assign hit_index = out_idx_reg;
    assign t_entry   = out_te_reg;
    assign t_exit    = out_tx_reg;
    assign point_x   = out_p_reg[0];
    assign point_y   = out_p_reg[1];
    assign point_z   = out_p_reg[2];
    assign normal_x  = out_n_reg[0];
    assign normal_y  = out_n_reg[1];
    assign normal_z  = out_n_reg[2];

    `RSNH_ASSERT_SAME(a_sqrt_steps, state_reg == S_SQRT, step_reg < 5'(SQRT_STEPS))
    `RSNH_ASSERT_SAME(a_hit_in_range, out_valid_reg && out_hit_reg, {1'b0, out_idx_reg} < limit)
    `RSNH_ASSERT_SAME(a_normal_range, out_valid_reg, (out_n_reg[0] <= 16'sd16384) && (out_n_reg[0] >= -16'sd16384))
    `RSNH_ASSERT_NEXT(a_result_loaded, state_reg == S_DONE && !out_valid_reg, out_valid_reg)

endmodule

@@ test/ray_sphere_nearest_hit_tb.sv @@
// Testbench for the ray/sphere nearest hit block: directed and random traffic checked against a predictor.
`timescale 1ns / 1ps
module ray_sphere_nearest_hit_tb;
    import rsnh_pkg::*;

    typedef struct packed {
        logic               hit;
        logic [3:0]         idx;
        logic signed [31:0] te;
        logic signed [31:0] tx;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } hit_rec_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic               cmd;
    logic [3:0]         entry_index;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        radius;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic               out_valid;
    logic               out_ready;
    logic               hit;
    logic [3:0]         hit_index;
    logic signed [31:0] t_entry;
    logic signed [31:0] t_exit;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;

    longint   cam[3];
    int       sphere_limit;
    longint   tbl_c[16][3];
    longint   tbl_r[16];
    hit_rec_t pending_hits[$];
    int       errors;
    int       burst_left;
    int       stall_mode;
    int       stall_left;

    ray_sphere_nearest_hit dut (.*);

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #(64'd80_000_000);
        $display("simulation failed");
        $finish;
    end

    function automatic longint sat_range(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint int_sqrt(longint v);
        longint res;
        longint b;
        res = 0;
        b = 64'sd1 <<< 62;
        while (b > v)
        begin
            b = b >>> 2;
        end
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >>> 1) + b;
            end
            else
            begin
                res = res >>> 1;
            end
            b = b >>> 2;
        end
        return res;
    endfunction

    function automatic hit_rec_t trace_ray(logic signed [15:0] dxi, logic signed [15:0] dyi,
                                           logic signed [15:0] dzi);
        longint   d[3];
        longint   bc[3];
        longint   oc;
        longint   h;
        longint   q;
        longint   s2;
        longint   h16;
        longint   hq;
        longint   rq;
        longint   disc;
        longint   sq;
        longint   t0;
        longint   a;
        longint   best_abs;
        longint   bt0;
        longint   bt1;
        longint   te;
        longint   tx;
        longint   p[3];
        longint   n[3];
        int       lim;
        int       best;
        bit       found;
        hit_rec_t r;
        d[0] = dxi;
        d[1] = dyi;
        d[2] = dzi;
        found = 1'b0;
        best = 0;
        best_abs = 0;
        bt0 = 0;
        bt1 = 0;
        r = '0;
        lim = sphere_limit > 16 ? 16 : sphere_limit;
        for (int i = 0; i < lim; i++)
        begin
            if (tbl_r[i] == 0)
            begin
                continue;
            end
            h = 0;
            s2 = 0;
            for (int k = 0; k < 3; k++)
            begin
                oc = cam[k] - tbl_c[i][k];
                h += d[k] * oc;
                q = oc >>> 8;
                s2 += q * q;
            end
            h16 = h >>> 14;
            hq = h16 >>> 8;
            rq = tbl_r[i] >>> 8;
            disc = hq * hq - (s2 - rq * rq);
            if (disc < 0)
            begin
                continue;
            end
            sq = int_sqrt(disc) * 256;
            t0 = -h16 - sq;
            a = t0 < 0 ? -t0 : t0;
            if (!found || a < best_abs)
            begin
                found = 1'b1;
                best_abs = a;
                best = i;
                bt0 = t0;
                bt1 = -h16 + sq;
                for (int k = 0; k < 3; k++)
                begin
                    bc[k] = tbl_c[i][k];
                end
            end
        end
        if (!found)
        begin
            return r;
        end
        te = sat_range(bt0, -64'sd2147483648, 64'sd2147483647);
        tx = sat_range(bt1, -64'sd2147483648, 64'sd2147483647);
        for (int k = 0; k < 3; k++)
        begin
            p[k] = sat_range(cam[k] + ((d[k] * te) >>> 14), -64'sd2147483648, 64'sd2147483647);
            n[k] = sat_range(((p[k] - bc[k]) * 16384) / tbl_r[best], -64'sd16384, 64'sd16384);
        end
        r.hit = 1'b1;
        r.idx = best[3:0];
        r.te = te[31:0];
        r.tx = tx[31:0];
        r.px = p[0][31:0];
        r.py = p[1][31:0];
        r.pz = p[2][31:0];
        r.nx = n[0][15:0];
        r.ny = n[1][15:0];
        r.nz = n[2][15:0];
        return r;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_CAMERA_X:     cam[0] = $signed(data);
            CFG_CAMERA_Y:     cam[1] = $signed(data);
            CFG_CAMERA_Z:     cam[2] = $signed(data);
            CFG_SPHERE_COUNT: sphere_limit = data[4:0];
            default:          ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_item(logic c, logic [3:0] slot, logic [31:0] cx, logic [31:0] cy,
                             logic [31:0] cz, logic [30:0] rad, logic [15:0] dx,
                             logic [15:0] dy, logic [15:0] dz);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd <= c;
        entry_index <= slot;
        center_x <= cx;
        center_y <= cy;
        center_z <= cz;
        radius <= rad;
        dir_x <= dx;
        dir_y <= dy;
        dir_z <= dz;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        if (c == CMD_LOAD)
        begin
            tbl_c[slot][0] = $signed(cx);
            tbl_c[slot][1] = $signed(cy);
            tbl_c[slot][2] = $signed(cz);
            tbl_r[slot] = rad;
        end
        else
        begin
            pending_hits.push_back(trace_ray(dx, dy, dz));
        end
    endtask

    task automatic load(logic [3:0] slot, logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                        logic [30:0] rad);
        send_item(CMD_LOAD, slot, cx, cy, cz, rad, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic trace(logic [15:0] dx, logic [15:0] dy, logic [15:0] dz);
        send_item(CMD_TRACE, 4'($urandom), $urandom, $urandom, $urandom, 31'($urandom),
                  dx, dy, dz);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        burst_left = 0;
        wait (pending_hits.size() == 0);
        repeat (100) @(posedge clk);
    endtask

    task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
        if (expv !== actv)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, expv, actv);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_mode = 0;
            stall_left = 0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 400);
            end
            else
            begin
                stall_left--;
            end
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= $urandom_range(0, 1);
                2:       out_ready <= ($urandom_range(0, 7) != 0);
                default: out_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        hit_rec_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_hits.size() == 0)
            begin
                $display("%0t: result transfer with nothing expected, actual hit %b index %0d",
                         $realtime, hit, hit_index);
                errors++;
            end
            else
            begin
                e = pending_hits.pop_front();
                check_field("hit", e.hit, hit);
                check_field("hit_index", e.idx, hit_index);
                check_field("t_entry", e.te, t_entry);
                check_field("t_exit", e.tx, t_exit);
                check_field("point_x", e.px, point_x);
                check_field("point_y", e.py, point_y);
                check_field("point_z", e.pz, point_z);
                check_field("normal_x", {{16{e.nx[15]}}, e.nx}, {{16{normal_x[15]}}, normal_x});
                check_field("normal_y", {{16{e.ny[15]}}, e.ny}, {{16{normal_y[15]}}, normal_y});
                check_field("normal_z", {{16{e.nz[15]}}, e.nz}, {{16{normal_z[15]}}, normal_z});
            end
        end
    end

    task automatic test_empty_table();
        trace(16'sd16384, 16'sd0, 16'sd0);
        wait_idle();
    endtask

    task automatic test_full_table();
        for (int i = 0; i < 16; i++)
        begin
            load(4'(i), 32'h0001_0000, 32'h0002_0000, 32'h0001_0000 + (i + 2) * 32'h0002_0000,
                 (i % 5 == 4) ? 31'd0 : 31'(31'h0000_8000 + i * 31'h1000));
        end
        wait_idle();
        write_reg(CFG_SPHERE_COUNT, 32'd16);
        trace(16'sd0, 16'sd0, 16'sd16384);
        trace(16'sd0, 16'sd0, -16'sd16384);
        wait_idle();
    endtask

    task automatic test_special_cases();
        write_reg(CFG_CAMERA_X, 32'd0);
        write_reg(CFG_CAMERA_Y, 32'd0);
        write_reg(CFG_CAMERA_Z, 32'd0);
        write_reg(CFG_SPHERE_COUNT, 32'd31);
        // Slot 0 grazes the x axis, slots 1 and 2 are the same sphere on the z axis.
        load(0, 32'd0, 32'h0003_0000, 32'd0, 31'h0003_0000);
        load(1, 32'd0, 32'd0, 32'h0005_0000, 31'h0001_0000);
        load(2, 32'd0, 32'd0, 32'h0005_0000, 31'h0001_0000);
        load(3, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff);
        trace(16'sd16384, 16'sd0, 16'sd0);
        trace(16'sd0, 16'sd0, 16'sd16384);
        trace(16'sd0, 16'sd0, -16'sd16384);
        trace(16'h7fff, 16'h8000, 16'sd0);
        trace(16'hffff, 16'h0000, 16'h8000);
        wait_idle();
        write_reg(CFG_CAMERA_X, 32'h7fff_ffff);
        write_reg(CFG_CAMERA_Y, 32'h8000_0000);
        write_reg(CFG_CAMERA_Z, 32'h7fff_ffff);
        trace(16'sd16384, 16'sd0, 16'sd0);
        trace(16'h8000, 16'h7fff, 16'h8000);
        wait_idle();
    endtask

    task automatic test_random(int n_items);
        logic [31:0] off[3];
        for (int it = 0; it < n_items; it++)
        begin
            if (it % 250 == 0)
            begin
                wait_idle();
                for (int k = 0; k < 3; k++)
                begin
                    write_reg(2'(k), ($urandom_range(0, 4) == 0) ? $urandom
                                     : $urandom_range(0, 32'h0010_0000) - 32'h0008_0000);
                end
                write_reg(CFG_SPHERE_COUNT, ($urandom_range(0, 3) == 0)
                                            ? $urandom_range(0, 31) : 16);
            end
            if ($urandom_range(0, 9) < 4)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    off[k] = 32'(cam[k] + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000);
                end
                if ($urandom_range(0, 4) == 0)
                begin
                    load(4'($urandom), $urandom, $urandom, $urandom, 31'($urandom));
                end
                else
                begin
                    load(4'($urandom), off[0], off[1], off[2],
                         ($urandom_range(0, 9) == 0) ? 31'd0
                         : 31'($urandom_range(32'h4000, 32'h0008_0000)));
                end
            end
            else if ($urandom_range(0, 6) == 0)
            begin
                trace(16'($urandom), 16'($urandom), 16'($urandom));
            end
            else
            begin
                trace(16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(0, 32768) - 16384),
                      16'($urandom_range(0, 32768) - 16384));
            end
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CAMERA_X;
        cfg_data = '0;
        in_valid = 1'b0;
        cmd = CMD_LOAD;
        entry_index = '0;
        center_x = '0;
        center_y = '0;
        center_z = '0;
        radius = '0;
        dir_x = '0;
        dir_y = '0;
        dir_z = '0;
        cam[0] = 65536;
        cam[1] = 131072;
        cam[2] = 65536;
        sphere_limit = 0;
        errors = 0;
        burst_left = 0;
        for (int i = 0; i < 16; i++)
        begin
            tbl_r[i] = 0;
            tbl_c[i] = '{0, 0, 0};
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_full_table();
        test_special_cases();
        test_random(1950);
        if (errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/rsnh_pkg.sv
sv/rsnh_table.sv
sv/ray_sphere_nearest_hit.sv
test/ray_sphere_nearest_hit_tb.sv
